// ----- hdl/assert_macros.svh -----
// assertion macros of the message header receiver, included by mhr_parser
// no dependencies; included inside module bodies that hold assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- hdl/mhr_pkg.sv -----
// types and constants of the message header receiver
// no dependencies; imported by mhr_parser, message_header_receiver and the testbench
package mhr_pkg;

    // sizes of the message format
    localparam int unsigned BUFFER_BYTES    = 256;
    localparam int unsigned MIN_MESSAGE_LEN = 13;
    localparam int unsigned HEADER_BYTES    = 7;

    localparam logic [7:0] SYNC_BYTE = 8'hA5;

    // item kinds
    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_TICK  = 2'd1;
    localparam logic [1:0] KIND_START = 2'd2;

    // end-of-read status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_REJECT  = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_LIMIT  = 1'b1;

    localparam logic [15:0] TIMEOUT_RESET = 16'd15000;
    localparam logic [7:0]  SEARCH_RESET  = 8'd243;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] rx_byte;
        logic [7:0] expected_opcode;
    } t_item;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] buffer_index;
        logic [7:0] stored_byte;
        logic       done_res;
        logic [1:0] status;
    } t_result;

endpackage

// ----- hdl/mhr_parser.sv -----
// read state and header parser of the message header receiver: one item per step
// depends on mhr_pkg and assert_macros.svh
module mhr_parser (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  mhr_pkg::t_item  i_item,
    input  logic [15:0]     i_timeout_limit,
    input  logic [7:0]      i_search_limit,
    output logic            o_res_valid,
    output mhr_pkg::t_result o_res
);
    import mhr_pkg::*;

    `include "assert_macros.svh"

    // read phases
    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_SYNC1   = 4'd1;
    localparam logic [3:0] PH_SYNC2   = 4'd2;
    localparam logic [3:0] PH_SEQ     = 4'd3;
    localparam logic [3:0] PH_INST    = 4'd4;
    localparam logic [3:0] PH_LENLO   = 4'd5;
    localparam logic [3:0] PH_LENHI   = 4'd6;
    localparam logic [3:0] PH_OPC     = 4'd7;
    localparam logic [3:0] PH_PAYLOAD = 4'd8;

    logic [3:0]  r_phase,   n_phase;
    logic [7:0]  r_opcode,  n_opcode;
    logic [7:0]  r_len_low, n_len_low;
    logic [8:0]  r_msg_len, n_msg_len;
    logic [8:0]  r_wpos,    n_wpos;
    logic [7:0]  r_seen,    n_seen;
    logic [7:0]  r_left,    n_left;
    logic [15:0] r_wait,    n_wait;

    logic        clr;
    logic        hdr_has;
    logic        ended;
    logic        matched;
    logic [8:0]  wpos_cur;
    logic [15:0] wait_inc;
    logic [15:0] len_full;
    logic [7:0]  left_dec;

    // next state and result of one item
    always_comb begin
        n_phase   = r_phase;
        n_opcode  = r_opcode;
        n_len_low = r_len_low;
        n_msg_len = r_msg_len;
        n_wpos    = r_wpos;
        n_seen    = r_seen;
        n_left    = r_left;
        n_wait    = r_wait;
        clr       = 1'b0;
        hdr_has   = 1'b0;
        ended     = 1'b0;
        matched   = 1'b0;
        o_res_valid = 1'b0;
        o_res     = '0;
        wpos_cur  = (r_phase == PH_SYNC1) ? 9'd0 : r_wpos;
        wait_inc  = r_wait + 16'd1;
        len_full  = {i_item.rx_byte, r_len_low};
        left_dec  = (r_left != 8'd0) ? (r_left - 8'd1) : r_left;

        if (i_step) begin
            case (i_item.kind)
                KIND_START: begin
                    clr = 1'b1;
                end
                KIND_TICK: begin
                    if (r_phase != PH_IDLE) begin
                        n_wait = wait_inc;
                        if (wait_inc >= i_timeout_limit) begin
                            clr            = 1'b1;
                            o_res_valid    = 1'b1;
                            o_res.done_res = 1'b1;
                            o_res.status   = ST_TIMEOUT;
                        end
                    end
                end
                KIND_BYTE: begin
                    if (r_phase == PH_PAYLOAD) begin
                        // payload byte, the wait count keeps running
                        n_wpos             = r_wpos + 9'd1;
                        n_left             = left_dec;
                        o_res_valid        = 1'b1;
                        o_res.has_byte     = 1'b1;
                        o_res.buffer_index = r_wpos[7:0];
                        o_res.stored_byte  = i_item.rx_byte;
                        if (left_dec == 8'd0) begin
                            clr            = 1'b1;
                            o_res.done_res = 1'b1;
                            o_res.status   = ST_OK;
                        end
                    end else if (r_phase != PH_IDLE) begin
                        // header byte restarts the wait count
                        n_wait = '0;
                        case (r_phase)
                            PH_SYNC1: begin
                                if (i_item.rx_byte == SYNC_BYTE) begin
                                    hdr_has = 1'b1;
                                    n_phase = PH_SYNC2;
                                end
                            end
                            PH_SYNC2: begin
                                if (i_item.rx_byte == SYNC_BYTE) begin
                                    hdr_has = 1'b1;
                                    n_phase = PH_SEQ;
                                end else begin
                                    ended = 1'b1;
                                end
                            end
                            PH_SEQ: begin
                                hdr_has = 1'b1;
                                n_phase = PH_INST;
                            end
                            PH_INST: begin
                                hdr_has = 1'b1;
                                if (i_item.rx_byte == 8'd1) begin
                                    n_phase = PH_LENLO;
                                end else begin
                                    ended = 1'b1;
                                end
                            end
                            PH_LENLO: begin
                                hdr_has   = 1'b1;
                                n_len_low = i_item.rx_byte;
                                n_phase   = PH_LENHI;
                            end
                            PH_LENHI: begin
                                hdr_has = 1'b1;
                                if (len_full < 16'(MIN_MESSAGE_LEN)) begin
                                    ended = 1'b1;
                                end else begin
                                    n_phase = PH_OPC;
                                end
                                // clip to the buffer size
                                if (len_full > 16'(BUFFER_BYTES)) begin
                                    n_msg_len = 9'(BUFFER_BYTES);
                                end else begin
                                    n_msg_len = len_full[8:0];
                                end
                            end
                            default: begin
                                if (i_item.rx_byte == r_opcode) begin
                                    hdr_has = 1'b1;
                                    matched = 1'b1;
                                end else begin
                                    ended = 1'b1;
                                end
                            end
                        endcase

                        n_seen = r_seen + 8'd1;
                        if (hdr_has) begin
                            n_wpos             = wpos_cur + 9'd1;
                            o_res.has_byte     = 1'b1;
                            o_res.buffer_index = wpos_cur[7:0];
                            o_res.stored_byte  = i_item.rx_byte;
                        end

                        if (matched) begin
                            // opcode match wins over the search limit
                            n_phase     = PH_PAYLOAD;
                            n_left      = 8'(r_msg_len - 9'(HEADER_BYTES));
                            o_res_valid = 1'b1;
                        end else if (ended || (n_seen >= i_search_limit)) begin
                            clr            = 1'b1;
                            o_res_valid    = 1'b1;
                            o_res.done_res = 1'b1;
                            o_res.status   = ST_REJECT;
                        end else if (hdr_has) begin
                            o_res_valid = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        // end of read or new start clears the read state
        if (clr) begin
            n_phase   = PH_IDLE;
            n_opcode  = '0;
            n_len_low = '0;
            n_msg_len = '0;
            n_wpos    = '0;
            n_seen    = '0;
            n_left    = '0;
            n_wait    = '0;
        end
        if (i_step && (i_item.kind == KIND_START)) begin
            n_opcode = i_item.expected_opcode;
            n_phase  = PH_SYNC1;
        end
    end

    // read state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_opcode  <= '0;
            r_len_low <= '0;
            r_msg_len <= '0;
            r_wpos    <= '0;
            r_seen    <= '0;
            r_left    <= '0;
            r_wait    <= '0;
        end else begin
            r_phase   <= n_phase;
            r_opcode  <= n_opcode;
            r_len_low <= n_len_low;
            r_msg_len <= n_msg_len;
            r_wpos    <= n_wpos;
            r_seen    <= n_seen;
            r_left    <= n_left;
            r_wait    <= n_wait;
        end
    end

    `ASSERT_CLK(a_idle_silent, (i_step && (r_phase == PH_IDLE) && (i_item.kind != KIND_START)) |-> !o_res_valid, "result without an active read")
    `ASSERT_CLK(a_done_ends_read, (i_step && o_res_valid && o_res.done_res) |=> (r_phase == PH_IDLE), "read still active after its end")
    `ASSERT_CLK(a_start_arms, (i_step && (i_item.kind == KIND_START)) |=> ((r_phase == PH_SYNC1) && (r_wpos == 9'd0)), "start did not arm a fresh read")
    `ASSERT_CLK(a_payload_pos, (r_phase == PH_PAYLOAD) |-> ((r_wpos >= 9'(HEADER_BYTES)) && (r_left != 8'd0)), "payload entered without a full header")

endmodule

// ----- hdl/message_header_receiver.sv -----
// top level of the message header receiver: stream ports, configuration, staging registers
// depends on mhr_pkg and mhr_parser
//
// Receive side of a framed serial message reader. A start transfer (tuser kind 2) arms a read
// with the opcode in tdata[15:8]; byte transfers (kind 0) then pass the header parser (two 0xA5
// sync bytes, sequence, instance 1, little-endian length of at least 13, clipped to 256, then
// the opcode) and the payload that follows. Every stored byte comes out with its position in
// the message; the last output transfer of a read carries tlast and its status. Idle poll
// ticks (kind 1) count toward timeout_limit; search_limit bounds the header bytes examined.
// One item is accepted every clock cycle while the output is not back-pressured; an item is
// held in the input register, its result is captured in the result register and presented
// from there. Only back-pressure on the output side slows the input. Configuration is to be
// written only while no read is in flight, which the block itself does not enforce; it takes
// effect on the next cycle.
module message_header_receiver (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input stream
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [15:0]                     i_s_tdata,  // rx_byte[7:0], expected_opcode[15:8]
    input  logic [1:0]                      i_s_tuser,  // kind[1:0]
    // result stream
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [15:0]                     o_m_tdata,  // buffer_index[7:0], stored_byte[15:8]
    output logic [2:0]                      o_m_tuser,  // has_byte[0], status[2:1]
    output logic                            o_m_tlast,  // done_res
    // configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mhr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mhr_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import mhr_pkg::*;

    logic [15:0] r_timeout_limit;
    logic [7:0]  r_search_limit;
    logic        r_in_valid;
    t_item       r_in_item;
    logic        r_out_valid;
    t_result     r_out;

    logic        out_free;
    logic        proc;
    logic        res_valid;
    t_result     res;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_limit <= TIMEOUT_RESET;
            r_search_limit  <= SEARCH_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TIMEOUT_LIMIT: r_timeout_limit <= i_cfg_data;
                CFG_SEARCH_LIMIT:  r_search_limit  <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // handshake between the stages
    assign out_free   = !r_out_valid || i_m_tready;
    assign proc       = r_in_valid && out_free;
    assign o_s_tready = !r_in_valid || out_free;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_item.kind            <= i_s_tuser;
            r_in_item.rx_byte         <= i_s_tdata[7:0];
            r_in_item.expected_opcode <= i_s_tdata[15:8];
        end
    end

    mhr_parser u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (proc),
        .i_item          (r_in_item),
        .i_timeout_limit (r_timeout_limit),
        .i_search_limit  (r_search_limit),
        .o_res_valid     (res_valid),
        .o_res           (res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= proc && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out.stored_byte, r_out.buffer_index};
    assign o_m_tuser  = {r_out.status, r_out.has_byte};
    assign o_m_tlast  = r_out.done_res;

endmodule

// ----- tb/tb_message_header_receiver.sv -----
`timescale 1ns / 100ps
// self-checking testbench of the message header receiver: header, payload, timeout, search limit
// depends on mhr_pkg and message_header_receiver; predicts every output transfer in place
module tb_message_header_receiver;
    import mhr_pkg::*;

    localparam logic [7:0] INSTANCE_ID = 8'd1;

    // kinds of damage a generated read may carry
    localparam int unsigned FLAW_NONE     = 0;
    localparam int unsigned FLAW_SYNC     = 1;
    localparam int unsigned FLAW_INSTANCE = 2;
    localparam int unsigned FLAW_LENGTH   = 3;
    localparam int unsigned FLAW_OPCODE   = 4;
    localparam int unsigned FLAW_RESTART  = 5;

    // pacing modes of the two stream sides
    localparam int unsigned PACE_STEADY = 0;
    localparam int unsigned PACE_RANDOM = 1;

    typedef enum logic [3:0] {
        RX_IDLE, RX_SYNC1, RX_SYNC2, RX_SEQ, RX_INST, RX_LENLO, RX_LENHI, RX_OPCODE, RX_PAYLOAD
    } rx_phase_e;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [15:0] i_s_tdata = '0;     // rx_byte[7:0], expected_opcode[15:8]
    logic [1:0]  i_s_tuser = '0;     // kind[1:0]
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [15:0] o_m_tdata;          // buffer_index[7:0], stored_byte[15:8]
    logic [2:0]  o_m_tuser;          // has_byte[0], status[2:1]
    logic        o_m_tlast;          // done_res
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    message_header_receiver dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // stimulus and expected output transfers
    t_item       rx_items[$];
    t_result     receiver_outputs[$];
    int unsigned pushed_total = 0;
    int unsigned taken_total = 0;
    int unsigned fail_count = 0;
    int unsigned cur_timeout = 32'(TIMEOUT_RESET);

    // handshake bookkeeping between the clocked blocks
    bit          src_taken = 0;
    bit          cfg_taken = 0;
    int unsigned src_wait = 0;
    int unsigned sink_wait = 0;
    int unsigned src_pace = PACE_STEADY;
    int unsigned sink_pace = PACE_STEADY;
    t_item       next_item;
    t_item       seen_item;
    t_result     seen_res;
    t_result     want_res;
    bit          made_res;

    // predicted receiver state and registers
    rx_phase_e   phase_q;
    logic [7:0]  op_wanted;
    logic [7:0]  len_lo;
    logic [8:0]  msg_len;
    logic [8:0]  wr_pos;
    logic [7:0]  hdr_seen;
    logic [8:0]  pay_left;
    logic [15:0] idle_cnt;
    logic [15:0] lim_timeout = TIMEOUT_RESET;
    logic [7:0]  lim_search = SEARCH_RESET;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic drop_read();
        phase_q = RX_IDLE;
        op_wanted = '0;
        len_lo = '0;
        msg_len = '0;
        wr_pos = '0;
        hdr_seen = '0;
        pay_left = '0;
        idle_cnt = '0;
    endtask

    // one receiver step: state update and the output transfer it causes, if any
    task automatic step_receiver(input t_item it, output bit got, output t_result res);
        bit          keep;
        bit          stop;
        bit          hit;
        logic [15:0] full_len;
        got = 0;
        res = '0;
        keep = 0;
        stop = 0;
        hit = 0;
        if (it.kind == KIND_START) begin
            drop_read();
            op_wanted = it.expected_opcode;
            phase_q = RX_SYNC1;
        end else if (phase_q == RX_IDLE || (it.kind != KIND_BYTE && it.kind != KIND_TICK)) begin
            got = 0;
        end else if (it.kind == KIND_TICK) begin
            idle_cnt = idle_cnt + 16'd1;
            if (idle_cnt >= lim_timeout) begin
                drop_read();
                got = 1;
                res.done_res = 1'b1;
                res.status = ST_TIMEOUT;
            end
        end else if (phase_q == RX_PAYLOAD) begin
            got = 1;
            res.has_byte = 1'b1;
            res.buffer_index = wr_pos[7:0];
            res.stored_byte = it.rx_byte;
            wr_pos = wr_pos + 9'd1;
            if (pay_left != 0) pay_left = pay_left - 9'd1;
            if (pay_left == 0) begin
                drop_read();
                res.done_res = 1'b1;
                res.status = ST_OK;
            end
        end else begin
            // header byte: restarts the idle count
            idle_cnt = '0;
            case (phase_q)
                RX_SYNC1: begin
                    if (it.rx_byte == SYNC_BYTE) begin
                        wr_pos = '0;
                        keep = 1;
                        phase_q = RX_SYNC2;
                    end
                end
                RX_SYNC2: begin
                    if (it.rx_byte == SYNC_BYTE) begin
                        keep = 1;
                        phase_q = RX_SEQ;
                    end else begin
                        stop = 1;
                    end
                end
                RX_SEQ: begin
                    keep = 1;
                    phase_q = RX_INST;
                end
                RX_INST: begin
                    keep = 1;
                    if (it.rx_byte == INSTANCE_ID) phase_q = RX_LENLO;
                    else stop = 1;
                end
                RX_LENLO: begin
                    keep = 1;
                    len_lo = it.rx_byte;
                    phase_q = RX_LENHI;
                end
                RX_LENHI: begin
                    keep = 1;
                    full_len = {it.rx_byte, len_lo};
                    if (full_len < MIN_MESSAGE_LEN) stop = 1;
                    else phase_q = RX_OPCODE;
                    if (full_len > BUFFER_BYTES) msg_len = 9'(BUFFER_BYTES);
                    else msg_len = full_len[8:0];
                end
                default: begin
                    if (it.rx_byte == op_wanted) begin
                        keep = 1;
                        hit = 1;
                    end else begin
                        stop = 1;
                    end
                end
            endcase
            if (keep) begin
                res.has_byte = 1'b1;
                res.buffer_index = wr_pos[7:0];
                res.stored_byte = it.rx_byte;
                wr_pos = wr_pos + 9'd1;
            end
            hdr_seen = hdr_seen + 8'd1;
            if (hit) begin
                // matching opcode goes on to the payload even at the search limit
                phase_q = RX_PAYLOAD;
                idle_cnt = '0;
                pay_left = msg_len - 9'(HEADER_BYTES);
                got = 1;
            end else if (stop || hdr_seen >= lim_search) begin
                drop_read();
                got = 1;
                res.done_res = 1'b1;
                res.status = ST_REJECT;
            end else begin
                got = keep;
            end
        end
    endtask

    task automatic log_failure(input string what, input t_result want, input t_result got);
        fail_count++;
        if (fail_count <= 10) begin
            $write("%0t %s: expected has=%0d idx=%0d byte=%02h done=%0d st=%0d,",
                   $time, what, want.has_byte, want.buffer_index, want.stored_byte,
                   want.done_res, want.status);
            $display(" got has=%0d idx=%0d byte=%02h done=%0d st=%0d",
                     got.has_byte, got.buffer_index, got.stored_byte, got.done_res,
                     got.status);
        end
    endtask

    function automatic int unsigned draw_wait(input int unsigned pace);
        if (pace == PACE_STEADY) return 0;
        if (pace == PACE_RANDOM) return $urandom_range(0, 18);
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
    endfunction

    // monitor: output transfers are checked, input transfers predicted, register writes mirrored
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                seen_res.has_byte = o_m_tuser[0];
                seen_res.status = o_m_tuser[2:1];
                seen_res.buffer_index = o_m_tdata[7:0];
                seen_res.stored_byte = o_m_tdata[15:8];
                seen_res.done_res = o_m_tlast;
                if (receiver_outputs.size() == 0) begin
                    log_failure("unexpected transfer", '0, seen_res);
                end else begin
                    want_res = receiver_outputs.pop_front();
                    if (seen_res.has_byte !== want_res.has_byte ||
                        seen_res.buffer_index !== want_res.buffer_index ||
                        seen_res.stored_byte !== want_res.stored_byte ||
                        seen_res.done_res !== want_res.done_res ||
                        seen_res.status !== want_res.status)
                        log_failure("mismatch", want_res, seen_res);
                end
                sink_wait = draw_wait(sink_pace);
            end
            if (i_s_tvalid && o_s_tready) begin
                seen_item.kind = i_s_tuser;
                seen_item.rx_byte = i_s_tdata[7:0];
                seen_item.expected_opcode = i_s_tdata[15:8];
                step_receiver(seen_item, made_res, want_res);
                if (made_res) receiver_outputs.push_back(want_res);
                src_taken = 1;
                taken_total++;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_TIMEOUT_LIMIT: lim_timeout = i_cfg_data;
                    CFG_SEARCH_LIMIT:  lim_search = i_cfg_data[7:0];
                    default: ;
                endcase
                cfg_taken = 1;
            end
        end
    end

    // input stream driver, fed from the item queue
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (i_s_tvalid && !src_taken) begin
            // hold the current item until its transfer
        end else if (src_wait != 0) begin
            i_s_tvalid <= 1'b0;
            src_wait--;
        end else if (rx_items.size() != 0) begin
            next_item = rx_items.pop_front();
            i_s_tdata <= {next_item.expected_opcode, next_item.rx_byte};
            i_s_tuser <= next_item.kind;
            i_s_tvalid <= 1'b1;
            src_wait = draw_wait(src_pace);
        end else begin
            i_s_tvalid <= 1'b0;
        end
        src_taken = 0;
    end

    // output stream back-pressure
    always @(negedge i_clk) begin
        if (sink_wait != 0) begin
            i_m_tready <= 1'b0;
            sink_wait--;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    task automatic push_item(input logic [1:0] k, input logic [7:0] b, input logic [7:0] op);
        t_item it;
        it.kind = k;
        it.rx_byte = b;
        it.expected_opcode = op;
        rx_items.push_back(it);
        pushed_total++;
    endtask

    task automatic push_byte(input logic [7:0] b);
        push_item(KIND_BYTE, b, 8'($urandom));
    endtask

    task automatic push_tick();
        push_item(KIND_TICK, 8'($urandom), 8'($urandom));
    endtask

    task automatic push_start(input logic [7:0] op);
        push_item(KIND_START, 8'($urandom), op);
    endtask

    function automatic logic [7:0] other_than(input logic [7:0] v);
        logic [7:0] r;
        r = 8'($urandom);
        return (r == v) ? ~v : r;
    endfunction

    // occasional burst of idle ticks, sized around the timeout
    task automatic add_ticks(input int unsigned tmo);
        if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, (tmo > 100) ? 3 : tmo + 1)) push_tick();
    endtask

    // one read: start, a little line noise, header, payload; some reads are damaged
    task automatic gen_read(input int unsigned tmo);
        logic [7:0]  hdr [0:6];
        logic [7:0]  op;
        logic [15:0] len;
        int unsigned flaw;
        int unsigned n_pay;
        op = 8'($urandom);
        flaw = ($urandom_range(0, 5) == 0) ? $urandom_range(FLAW_SYNC, FLAW_RESTART) : FLAW_NONE;
        if ($urandom_range(0, 39) == 0) len = 16'($urandom_range(256, 65535));
        else len = 16'($urandom_range(MIN_MESSAGE_LEN, 40));
        if (flaw == FLAW_LENGTH) len = 16'($urandom_range(0, MIN_MESSAGE_LEN - 1));
        hdr[0] = SYNC_BYTE;
        hdr[1] = (flaw == FLAW_SYNC) ? other_than(SYNC_BYTE) : SYNC_BYTE;
        hdr[2] = 8'($urandom);
        hdr[3] = (flaw == FLAW_INSTANCE) ? other_than(INSTANCE_ID) : INSTANCE_ID;
        hdr[4] = len[7:0];
        hdr[5] = len[15:8];
        hdr[6] = (flaw == FLAW_OPCODE) ? other_than(op) : op;
        push_start(op);
        repeat ($urandom_range(0, 2)) begin
            add_ticks(tmo);
            push_byte(other_than(SYNC_BYTE));
        end
        for (int i = 0; i < 7; i++) begin
            add_ticks(tmo);
            push_byte(hdr[i]);
            if (flaw == FLAW_RESTART && i == 3) return;
        end
        if (flaw != FLAW_NONE) begin
            // stray byte after the reject is ignored
            push_byte(8'($urandom));
            return;
        end
        n_pay = ((len > BUFFER_BYTES) ? BUFFER_BYTES : len) - HEADER_BYTES;
        repeat (n_pay) begin
            add_ticks(tmo);
            push_byte(8'($urandom));
        end
    endtask

    task automatic fill_reads(input int unsigned upto);
        while (pushed_total < upto) begin
            // stray item of any kind, the unused kind included
            if ($urandom_range(0, 4) == 0)
                push_item(2'($urandom), 8'($urandom), 8'($urandom));
            gen_read(cur_timeout);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        while (!cfg_taken) @(negedge i_clk);
        cfg_taken = 0;
        i_cfg_valid <= 1'b0;
    endtask

    // sender holds off until every item is taken and every expected transfer has come
    task automatic drain_block();
        int unsigned waited;
        waited = 0;
        while (taken_total != pushed_total) @(negedge i_clk);
        while (receiver_outputs.size() != 0 && waited < 2000) begin
            @(negedge i_clk);
            waited++;
        end
        if (receiver_outputs.size() != 0) begin
            fail_count += receiver_outputs.size();
            $display("%0t %0d expected transfers never arrived", $time, receiver_outputs.size());
            receiver_outputs.delete();
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic new_phase(input logic [15:0] tmo, input logic [7:0] srch);
        drain_block();
        write_reg(CFG_TIMEOUT_LIMIT, tmo);
        write_reg(CFG_SEARCH_LIMIT, {8'h00, srch});
        cur_timeout = 32'(tmo);
        src_pace = $urandom_range(0, 2);
        sink_pace = $urandom_range(0, 2);
    endtask

    initial begin
        drop_read();
        src_pace = $urandom_range(0, 2);
        sink_pace = $urandom_range(0, 2);
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // ignored while no read is armed
        push_byte(8'hFF); push_tick();
        // second sync byte missing, after one skipped byte
        push_start(8'hFF); push_byte(8'h00); push_byte(SYNC_BYTE); push_byte(8'h00);
        // instance other than one
        push_start(8'h00); push_byte(SYNC_BYTE); push_byte(SYNC_BYTE); push_byte(8'hFF);
        push_byte(8'h00);
        // length below the minimum
        push_start(8'h3C); push_byte(SYNC_BYTE); push_byte(SYNC_BYTE); push_byte(8'h00);
        push_byte(INSTANCE_ID); push_byte(8'(MIN_MESSAGE_LEN - 1)); push_byte(8'h00);
        // longest length, then an opcode mismatch
        push_start(8'h00); push_byte(SYNC_BYTE); push_byte(SYNC_BYTE); push_byte(8'h7E);
        push_byte(INSTANCE_ID); push_byte(8'hFF); push_byte(8'hFF); push_byte(8'h01);
        // start during a read, then the shortest message
        push_start(8'hFF); push_byte(SYNC_BYTE);
        push_start(8'h00); push_byte(SYNC_BYTE); push_byte(SYNC_BYTE); push_byte(8'h00);
        push_byte(INSTANCE_ID); push_byte(8'(MIN_MESSAGE_LEN)); push_byte(8'h00);
        push_byte(8'h00);
        push_tick(); push_byte(8'hFF); push_byte(8'h00); push_byte(8'hFF);
        push_byte(8'h00); push_byte(8'hFF); push_byte(8'h00);
        fill_reads(350);

        // largest limits
        new_phase(16'hFFFF, 8'hFF);
        fill_reads(pushed_total + 250);

        // zero limits: first tick times out, first header byte ends the search
        new_phase(16'd0, 8'd0);
        push_start(8'h00); push_tick();
        push_start(8'h00); push_byte(8'h00);
        push_start(8'h5A); push_byte(SYNC_BYTE);
        fill_reads(pushed_total + 25);

        // smallest legal limits
        new_phase(16'd1, 8'd1);
        fill_reads(pushed_total + 30);

        // search limit reached on a matching opcode, cumulative payload timeout,
        // header timeout
        new_phase(16'd3, 8'(HEADER_BYTES));
        push_start(8'h42); push_byte(SYNC_BYTE); push_byte(SYNC_BYTE); push_byte(8'h01);
        push_byte(INSTANCE_ID); push_byte(8'(MIN_MESSAGE_LEN)); push_byte(8'h00);
        push_byte(8'h42);
        push_byte(8'hC3); push_tick(); push_byte(8'h3C); push_tick(); push_tick();
        push_start(8'h42); push_byte(SYNC_BYTE); push_tick(); push_tick(); push_tick();
        fill_reads(pushed_total + 40);

        // random limits
        repeat (4) begin
            new_phase(16'($urandom_range(2, 60)), 8'($urandom_range(8, 40)));
            fill_reads(pushed_total + 160);
        end

        drain_block();
        repeat (8) @(negedge i_clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
